>>> design/rcx_pkg.sv
// Shared types, constants and the weight table for the raised-cosine crossfader.
package rcx_pkg;

	localparam int LANES       = 2;
	localparam int SAMPLE_BITS = 24;
	localparam int TABLE_DEPTH = 1024;
	localparam int WEIGHT_BITS = 16;

	localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = DIFF_BITS + WEIGHT_BITS + 2;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// operation codes
	localparam logic [1:0] OP_PROCESS = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_STOP    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FADE_LENGTH = 2'd0;
	localparam logic [1:0] CFG_PHASE_STEP  = 2'd1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [WEIGHT_BITS:0] weight_t;   // Q1.16, up to 1.0 inclusive
	typedef weight_t weight_rom_t [TABLE_DEPTH];

	typedef struct packed {
		logic [1:0] operation;
		sample_t    new_sample_0;
		sample_t    new_sample_1;
		sample_t    old_sample_0;
		sample_t    old_sample_1;
	} frame_t;

	typedef struct packed {
		sample_t mixed_0;
		sample_t mixed_1;
		logic    crossing;
	} mix_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_en_t;

	// shift-and-subtract quotient, only evaluated while building the table
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Q30 cosine, eleven-term Taylor series with truncating steps
	function automatic logic [63:0] cos_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        div;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		sum  = signed'(ONE_Q30);
		for (int k = 0; k < 10; k++) begin
			div  = 64'((2 * k + 1) * (2 * k + 2));
			term = long_div((term * x2) >> 30, div);
			if ((k & 1) == 0)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = '0;
		if (sum > signed'(ONE_Q30))
			sum = signed'(ONE_Q30);
		return unsigned'(sum);
	endfunction

	function automatic weight_rom_t build_rom();
		weight_rom_t rom;
		logic [63:0] x;
		logic [63:0] w30;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (2 * i <= TABLE_DEPTH) begin
				x   = (PI_Q30 * 64'(i)) / TABLE_DEPTH;
				w30 = (ONE_Q30 - cos_q30(x)) >> 1;
			end else begin
				x   = (PI_Q30 * 64'(TABLE_DEPTH - i)) / TABLE_DEPTH;
				w30 = (ONE_Q30 + cos_q30(x)) >> 1;
			end
			rom[i] = weight_t'((w30 + (64'd1 << (29 - WEIGHT_BITS))) >> (30 - WEIGHT_BITS));
		end
		return rom;
	endfunction

	localparam weight_rom_t WEIGHT_ROM = build_rom();

endpackage

>>> design/rcx_ctrl.sv
// Fade control: configuration registers, fade counter, phase accumulator, weight lookup.
module rcx_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [1:0]              operation,
	input  rcx_pkg::pipe_en_t       pen,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	output rcx_pkg::weight_t        weight_s1,
	output logic                    crossing_s2
);
	import rcx_pkg::*;

	logic [15:0] fade_length_q;
	logic [31:0] phase_step_q;
	logic [15:0] frames_left_q;
	logic [31:0] phase_q;
	logic        crossing_s1;
	logic        fading;

	assign fading = (frames_left_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_length_q <= 16'd960;
			phase_step_q  <= 32'd4473924;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FADE_LENGTH: fade_length_q <= cfg_data[15:0];
				CFG_PHASE_STEP:  phase_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_left_q <= '0;
			phase_q       <= '0;
		end else if (accept) begin
			case (operation)
				OP_PROCESS: begin
					if (fading) begin
						phase_q       <= phase_q + phase_step_q;
						frames_left_q <= frames_left_q - 16'd1;
					end
				end
				OP_START: begin
					if (!fading) begin
						frames_left_q <= (fade_length_q == '0) ? 16'd1 : fade_length_q;
						phase_q       <= '0;
					end
				end
				OP_STOP: frames_left_q <= '0;
				default: ;
			endcase
		end
	end

	// Outside a fade the weight is exactly 1.0, so the lanes pass the new sample.
	always_ff @(posedge clk) begin
		if (pen.en_s1) begin
			weight_s1   <= fading ? WEIGHT_ROM[phase_q[31 -: IDX_BITS]]
			                      : weight_t'(1) << WEIGHT_BITS;
			crossing_s1 <= fading;
		end
		if (pen.en_s2)
			crossing_s2 <= crossing_s1;
	end

endmodule

>>> design/rcx_lane.sv
// One blend lane: difference, weighted product, rounding and add back to the old sample.
module rcx_lane (
	input  logic              clk,
	input  rcx_pkg::pipe_en_t pen,
	input  rcx_pkg::sample_t  new_sample,
	input  rcx_pkg::sample_t  old_sample,
	input  rcx_pkg::weight_t  weight_s1,
	output rcx_pkg::sample_t  mixed
);
	import rcx_pkg::*;

	logic signed [DIFF_BITS-1:0] diff_s1;
	sample_t                     old_s1;
	sample_t                     old_s2;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [PROD_BITS-1:0] rounded;
	logic signed [PROD_BITS-1:0] total;

	always_ff @(posedge clk) begin
		if (pen.en_s1) begin
			diff_s1 <= DIFF_BITS'(new_sample) - DIFF_BITS'(old_sample);
			old_s1  <= old_sample;
		end
		if (pen.en_s2) begin
			prod_s2 <= PROD_BITS'(signed'({1'b0, weight_s1})) * PROD_BITS'(diff_s1);
			old_s2  <= old_s1;
		end
	end

	// round half up, floor shift
	assign rounded = (prod_s2 + (PROD_BITS'(1) <<< (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
	assign total   = rounded + PROD_BITS'(old_s2);
	assign mixed   = total[SAMPLE_BITS-1:0];

endmodule

>>> design/raised_cosine_crossfader.sv
// Top level of the raised-cosine crossfader: handshake pipeline, lanes and output merge.
//
// frame channel (frame_valid / frame_stall / frame): one transaction per
// command or audio frame. operation selects process, start fade or stop fade.
// Start and stop update the fade state and give no result; a process frame
// gives exactly one transaction on the mix channel (mix_valid / mix_stall / mix).
// Configuration: cfg_valid / cfg_ready with cfg_index (0 fade_length,
// 1 phase_step) and cfg_data; cfg_ready is always high, other indexes are dropped.
// Throughput: one frame per cycle while mix is not stalled. Each lane has a
// difference stage and a multiply stage, the weight comes from the half-cosine
// table in the first stage, and an output register merges the lanes: a processed
// frame passes the difference stage and the multiply stage before it is loaded
// into the mix register, from which it can be taken on mix.
// A stall on mix holds the output register; the frame side keeps accepting
// until every stage holds a result, then raises frame_stall.
// Reset: no fade running, phase zero, fade_length 960, phase_step 4473924,
// pipeline empty.
module raised_cosine_crossfader (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            frame_valid,
	output logic            frame_stall,
	input  rcx_pkg::frame_t frame,
	output logic            mix_valid,
	input  logic            mix_stall,
	output rcx_pkg::mix_t   mix,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data
);
	import rcx_pkg::*;

	pipe_en_t pen;
	logic     accept;
	logic     valid_s1;
	logic     valid_s2;
	logic     out_valid_q;
	logic     en_out;
	logic     crossing_s2;
	weight_t  weight_s1;
	sample_t  new_lane [LANES];
	sample_t  old_lane [LANES];
	sample_t  mixed_lane [LANES];

	assign en_out     = !out_valid_q || !mix_stall;
	assign pen.en_s2  = !valid_s2 || en_out;
	assign pen.en_s1  = !valid_s1 || pen.en_s2;
	assign frame_stall = !pen.en_s1;
	assign accept     = frame_valid && pen.en_s1;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pen.en_s1)
				valid_s1 <= accept && (frame.operation == OP_PROCESS);
			if (pen.en_s2)
				valid_s2 <= valid_s1;
			if (en_out)
				out_valid_q <= valid_s2;
		end
	end

	assign new_lane[0] = frame.new_sample_0;
	assign new_lane[1] = frame.new_sample_1;
	assign old_lane[0] = frame.old_sample_0;
	assign old_lane[1] = frame.old_sample_1;

	rcx_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (frame.operation),
		.pen         (pen),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.weight_s1   (weight_s1),
		.crossing_s2 (crossing_s2)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		rcx_lane u_lane (
			.clk        (clk),
			.pen        (pen),
			.new_sample (new_lane[l]),
			.old_sample (old_lane[l]),
			.weight_s1  (weight_s1),
			.mixed      (mixed_lane[l])
		);
	end

	// merge the lanes into the output register
	always_ff @(posedge clk) begin
		if (en_out) begin
			mix.mixed_0  <= mixed_lane[0];
			mix.mixed_1  <= mixed_lane[1];
			mix.crossing <= crossing_s2;
		end
	end

	assign mix_valid = out_valid_q;

endmodule

>>> verif/raised_cosine_crossfader_test.sv
// Self-checking testbench for the raised-cosine crossfader: directed table, then random frames.
module raised_cosine_crossfader_test;
	import rcx_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int              ROM_DEPTH     = 1024;
	localparam int              W_BITS        = 16;
	localparam longint unsigned ONE_Q30       = 64'd1 << 30;
	localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
	localparam int              CYCLE_LIMIT   = 200000;
	localparam int              SETTLE_CYCLES = 6;
	localparam int              REPORT_LIMIT  = 10;
	localparam int              DIRECTED_ROWS = 23;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd2;

	localparam sample_t SMAX = 24'sh7FFFFF;
	localparam sample_t SMIN = 24'sh800000;
	localparam sample_t S0   = '0;
	localparam mix_t    NO_MIX = '0;

	typedef logic [W_BITS:0] fade_weight_t;

	typedef struct {
		frame_t stim;
		bit     typed;
		mix_t   want;
	} dir_row_t;

	logic    clk;
	logic    arst_n      = 1'b0;
	logic    frame_valid = 1'b0;
	logic    frame_stall;
	frame_t  frame       = '0;
	logic    mix_valid;
	logic    mix_stall   = 1'b0;
	mix_t    mix;
	logic    cfg_valid   = 1'b0;
	logic    cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	// fader state mirrored by the predictor
	fade_weight_t fade_weight [ROM_DEPTH];
	logic [15:0]  fade_len_reg   = 16'd960;
	logic [31:0]  phase_step_reg = 32'd4473924;
	logic [15:0]  fade_left      = '0;
	logic [31:0]  fade_phase     = '0;

	mix_t pending_mix [$];
	int   fail_count  = 0;
	int   cycle_count = 0;
	int   gap_pct     = 0;
	int   stall_pct   = 0;

	dir_row_t directed [DIRECTED_ROWS] = '{
		'{'{OP_PROCESS, SMAX, SMIN, S0, S0}, 1'b1, '{SMAX, SMIN, 1'b0}},
		'{'{OP_PROCESS, S0, -24'sd1, SMIN, SMAX}, 1'b1, '{S0, -24'sd1, 1'b0}},
		'{'{OP_STOP, 24'sd1, 24'sd2, 24'sd3, 24'sd4}, 1'b0, NO_MIX},
		'{'{OP_UNUSED, SMAX, SMAX, SMAX, SMAX}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, 24'sh123456, -24'sh0ABCDE, SMAX, SMIN}, 1'b1,
			'{24'sh123456, -24'sh0ABCDE, 1'b0}},
		'{'{OP_START, S0, S0, S0, S0}, 1'b0, NO_MIX},
		// first frame of a fade has zero weight: old sample comes through
		'{'{OP_PROCESS, SMAX, SMIN, SMIN, SMAX}, 1'b1, '{SMIN, SMAX, 1'b1}},
		'{'{OP_PROCESS, SMAX, SMIN, SMIN, SMAX}, 1'b0, NO_MIX},
		'{'{OP_START, SMAX, SMAX, SMAX, SMAX}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, SMIN, SMAX, SMAX, SMIN}, 1'b0, NO_MIX},
		'{'{OP_UNUSED, S0, S0, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, 24'sh400000, -24'sh400000, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, -24'sd1000, SMAX, -24'sd1000, SMAX}, 1'b1,
			'{-24'sd1000, SMAX, 1'b1}},
		'{'{OP_PROCESS, SMAX, SMAX, SMIN, SMIN}, 1'b0, NO_MIX},
		'{'{OP_STOP, S0, S0, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_STOP, S0, S0, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, SMAX, SMIN, SMIN, SMAX}, 1'b1, '{SMAX, SMIN, 1'b0}},
		'{'{OP_START, S0, S0, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, 24'sd1, -24'sd1, S0, S0}, 1'b1, '{S0, S0, 1'b1}},
		'{'{OP_PROCESS, SMAX, SMIN, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, -24'sd1, 24'sd1, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_STOP, S0, S0, S0, S0}, 1'b0, NO_MIX},
		'{'{OP_PROCESS, 24'sd5, 24'sd6, 24'sd7, 24'sd8}, 1'b1, '{24'sd5, 24'sd6, 1'b0}}
	};

	raised_cosine_crossfader dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.mix_valid   (mix_valid),
		.mix_stall   (mix_stall),
		.mix         (mix),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Q30 cosine by truncating Taylor terms
	function automatic longint unsigned cos_taylor_q30(input longint unsigned x);
		longint unsigned sq;
		longint unsigned term;
		longint          acc;
		sq   = (x * x) >> 30;
		term = ONE_Q30;
		acc  = longint'(ONE_Q30);
		for (int k = 0; k < 10; k++) begin
			term = ((term * sq) >> 30) / longint'((2 * k + 1) * (2 * k + 2));
			if (k % 2 == 0)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > longint'(ONE_Q30))
			acc = longint'(ONE_Q30);
		return longint'(acc);
	endfunction

	initial begin
		longint unsigned x;
		longint unsigned w30;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			if (2 * i <= ROM_DEPTH) begin
				x   = (HALF_TURN_Q30 * longint'(i)) / ROM_DEPTH;
				w30 = (ONE_Q30 - cos_taylor_q30(x)) >> 1;
			end else begin
				x   = (HALF_TURN_Q30 * longint'(ROM_DEPTH - i)) / ROM_DEPTH;
				w30 = (ONE_Q30 + cos_taylor_q30(x)) >> 1;
			end
			fade_weight[i] = fade_weight_t'((w30 + (ONE_Q30 >> (W_BITS + 1))) >> (30 - W_BITS));
		end
	end

	// old + w*(new-old), product rounded half up before the shift
	function automatic sample_t blend_lane(input sample_t nw, input sample_t od,
			input fade_weight_t w);
		longint d;
		longint p;
		d = longint'(nw) - longint'(od);
		p = longint'(w) * d + (longint'(1) << (W_BITS - 1));
		return sample_t'(longint'(od) + (p >>> W_BITS));
	endfunction

	// advances the mirrored fade state; returns 1 when the frame yields a mix
	function automatic bit step_fader(input frame_t f, output mix_t m);
		fade_weight_t w;
		m = '0;
		case (f.operation)
			OP_START: begin
				if (fade_left == 0) begin
					fade_left  = (fade_len_reg == 0) ? 16'd1 : fade_len_reg;
					fade_phase = '0;
				end
				return 1'b0;
			end
			OP_STOP: begin
				fade_left = '0;
				return 1'b0;
			end
			OP_PROCESS: ;
			default: return 1'b0;
		endcase
		if (fade_left != 0) begin
			w = fade_weight[10'((longint'(fade_phase) * ROM_DEPTH) >> 32)];
			m.mixed_0  = blend_lane(f.new_sample_0, f.old_sample_0, w);
			m.mixed_1  = blend_lane(f.new_sample_1, f.old_sample_1, w);
			m.crossing = 1'b1;
			fade_phase = fade_phase + phase_step_reg;
			fade_left  = fade_left - 16'd1;
		end else begin
			m.mixed_0  = f.new_sample_0;
			m.mixed_1  = f.new_sample_1;
			m.crossing = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(15))
			0: return SMAX;
			1: return SMIN;
			2: return S0;
			3: return -24'sd1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int     r;
		r = $urandom_range(99);
		if (r < 70)
			f.operation = OP_PROCESS;
		else if (r < 82)
			f.operation = OP_START;
		else if (r < 95)
			f.operation = OP_STOP;
		else
			f.operation = OP_UNUSED;
		f.new_sample_0 = random_sample();
		f.new_sample_1 = random_sample();
		f.old_sample_0 = random_sample();
		f.old_sample_1 = random_sample();
		return f;
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	task automatic send_frame(input frame_t f, input bit typed, input mix_t typed_mix);
		mix_t predicted;
		@(negedge clk);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			frame_valid <= 1'b0;
			@(negedge clk);
		end
		frame_valid <= 1'b1;
		frame       <= f;
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
		if (step_fader(f, predicted))
			pending_mix.push_back(typed ? typed_mix : predicted);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_FADE_LENGTH: fade_len_reg   = data[15:0];
			CFG_PHASE_STEP:  phase_step_reg = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] len_word, input logic [31:0] step);
		write_reg(CFG_FADE_LENGTH, len_word);
		write_reg(CFG_PHASE_STEP, step);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		frame_t f;
		int     sent;
		sent = 0;
		while (sent < count) begin
			f = random_frame();
			send_frame(f, 1'b0, NO_MIX);
			if (f.operation != OP_UNUSED)
				sent++;
		end
		@(negedge clk);
		frame_valid <= 1'b0;
	endtask

	// start and stop leave no trace on mix, so give the pipe time to settle
	task automatic drain();
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk)
		mix_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		mix_t want;
		if (arst_n && mix_valid && !mix_stall) begin
			if (pending_mix.size() == 0) begin
				log_failure($sformatf("mix transaction with nothing pending: %0d %0d %0b",
					mix.mixed_0, mix.mixed_1, mix.crossing));
			end else begin
				want = pending_mix.pop_front();
				if (mix.mixed_0 !== want.mixed_0 || mix.mixed_1 !== want.mixed_1 ||
						mix.crossing !== want.crossing)
					log_failure($sformatf(
						"mix mismatch: expected %0d %0d %0b, got %0d %0d %0b",
						want.mixed_0, want.mixed_1, want.crossing,
						mix.mixed_0, mix.mixed_1, mix.crossing));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int len;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_frame(directed[r].stim, directed[r].typed, directed[r].want);
		@(negedge clk);
		frame_valid <= 1'b0;
		drain();

		// shortest fade, largest step
		configure(32'd1, 32'hFFFF_FFFF);
		gap_pct   = 0;
		stall_pct = 0;
		run_random(90);
		drain();

		// longest fade, with a step that sweeps the phase once over it; a write to an unmapped index must be dropped
		write_reg(CFG_UNUSED, $urandom);
		configure(32'hFFFF, 32'd65537);
		gap_pct   = 63;
		stall_pct = 0;
		run_random(90);
		drain();

		// zero length gives one-frame fades; upper data bits are dropped
		configure(32'hABCD_0000, 32'd0);
		gap_pct   = 0;
		stall_pct = 63;
		run_random(90);
		drain();

		len = $urandom_range(40, 2);
		configure(32'(len), 32'((64'd1 << 32) / len));
		gap_pct   = 25;
		stall_pct = 25;
		run_random(90);
		drain();

		// mismatched step lets the phase wrap
		configure(32'($urandom_range(300, 1)), $urandom);
		gap_pct   = 0;
		stall_pct = 0;
		run_random(90);
		drain();

		if (fail_count == 0 && pending_mix.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
